// ===== rtl/gerd_pkg.sv =====
// gerd_pkg: shared types and constants of the gamepad edge, repeat and dead zone unit.
// Holds the configuration word type, register indexes and reset values.
// Used by gerd_lane and gamepad_edge_repeat_deadzone_unit.
`timescale 1ns / 1ps

package gerd_pkg;

   localparam int NUM_BUTTONS = 32;
   localparam int MASK_WIDTH  = 32;
   localparam int CNT_WIDTH   = 9;

   localparam logic [MASK_WIDTH-1:0] BUTTON_MASK =
      (NUM_BUTTONS >= MASK_WIDTH) ? {MASK_WIDTH{1'b1}}
                                  : MASK_WIDTH'((64'd1 << NUM_BUTTONS) - 64'd1);

   typedef enum logic [1:0] {
      REG_HOLD_DELAY    = 2'd0,
      REG_REPEAT_PERIOD = 2'd1,
      REG_DEAD_ZONE     = 2'd2
   } reg_index_type;

   localparam logic [7:0] RESET_HOLD_DELAY    = 8'd30;
   localparam logic [7:0] RESET_REPEAT_PERIOD = 8'd6;
   localparam logic [7:0] RESET_DEAD_ZONE     = 8'd20;

   typedef struct packed {
      logic [7:0] hold_delay;
      logic [7:0] repeat_period;
      logic [7:0] dead_zone;
   } cfg_type;

endpackage

// ===== rtl/gerd_lane.sv =====
// gerd_lane: hold counter and auto-repeat decision of one button.
// Depends on gerd_pkg (cfg_type, CNT_WIDTH).
`timescale 1ns / 1ps

module gerd_lane (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             held,
   input  gerd_pkg::cfg_type cfg,
   output logic             fire
);

   logic [gerd_pkg::CNT_WIDTH-1:0] cnt_ff;
   logic [gerd_pkg::CNT_WIDTH-1:0] cnt_in;
   logic [gerd_pkg::CNT_WIDTH:0]   count_next;
   logic [gerd_pkg::CNT_WIDTH:0]   delay_ext;
   logic [gerd_pkg::CNT_WIDTH:0]   past_delay;
   logic                           wrap;

   always_comb begin
      count_next = {1'b0, cnt_ff} + (gerd_pkg::CNT_WIDTH+1)'(1);
      delay_ext  = (gerd_pkg::CNT_WIDTH+1)'(cfg.hold_delay);
      past_delay = count_next - delay_ext;
      // a zero period behaves as one: past_delay is at least 1 here anyway
      wrap = (count_next > delay_ext) &&
             (past_delay >= (gerd_pkg::CNT_WIDTH+1)'(cfg.repeat_period));
      fire = 1'b0;
      cnt_in = '0;
      if (held) begin
         fire = wrap || (count_next == (gerd_pkg::CNT_WIDTH+1)'(1));
         cnt_in = wrap ? gerd_pkg::CNT_WIDTH'(cfg.hold_delay)
                       : count_next[gerd_pkg::CNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (advance) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/gerd_stick.sv =====
// gerd_stick: centers one stick sample and applies the dead zone.
// Stands alone; the top level feeds it the dead zone register.
`timescale 1ns / 1ps

module gerd_stick (
   input  logic        [7:0] raw,
   input  logic        [7:0] dead_zone,
   output logic signed [7:0] offset
);

   logic [7:0] centered;
   logic [7:0] magnitude;

   always_comb begin
      // raw - 128 in two's complement is a flip of the top bit
      centered  = raw ^ 8'h80;
      magnitude = centered[7] ? (~centered + 8'd1) : centered;
      offset    = (magnitude < dead_zone) ? 8'sd0 : $signed(centered);
   end

endmodule

// ===== rtl/gamepad_edge_repeat_deadzone_unit.sv =====
// gamepad_edge_repeat_deadzone_unit: button edges, hold, auto-repeat and stick dead zone.
// An accepted req word becomes the rsp word in the output register in the cycle after.
// One word per cycle when not stalled; button lanes and stick paths are combinational.
// Reset (synchronous): hold counters and previous mask cleared, registers back to
// delay 30, period 6, dead zone 20, output register empty.
// Depends on gerd_pkg, gerd_lane, gerd_stick.
`timescale 1ns / 1ps

module gamepad_edge_repeat_deadzone_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel: one pad frame per word
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [31:0] req_buttons,
   input  logic        [7:0]  req_stick_x_raw,
   input  logic        [7:0]  req_stick_y_raw,
   // response channel: one decoded frame per word
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [31:0] rsp_pressed_mask,
   output logic        [31:0] rsp_released_mask,
   output logic        [31:0] rsp_held_mask,
   output logic        [31:0] rsp_repeat_mask,
   output logic signed [7:0]  rsp_stick_x_offset,
   output logic signed [7:0]  rsp_stick_y_offset,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [7:0]  csr_data
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   gerd_pkg::cfg_type cfg_ff;
   gerd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (gerd_pkg::reg_index_type'(csr_index))
            gerd_pkg::REG_HOLD_DELAY:    cfg_in.hold_delay    = csr_data;
            gerd_pkg::REG_REPEAT_PERIOD: cfg_in.repeat_period = csr_data;
            gerd_pkg::REG_DEAD_ZONE:     cfg_in.dead_zone     = csr_data;
            default:                     cfg_in = cfg_ff; // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_delay    <= gerd_pkg::RESET_HOLD_DELAY;
         cfg_ff.repeat_period <= gerd_pkg::RESET_REPEAT_PERIOD;
         cfg_ff.dead_zone     <= gerd_pkg::RESET_DEAD_ZONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // handshake: take a new word whenever the output register is empty
   // or being drained in this same cycle
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // button lanes: one hold counter per button, all side by side
   // ---------------------------------------------------------------
   logic [31:0]                     cur_buttons;
   logic [gerd_pkg::NUM_BUTTONS-1:0] lane_fire;
   logic [31:0]                     repeat_in;

   // ignore buttons beyond the implemented count
   assign cur_buttons = req_buttons & gerd_pkg::BUTTON_MASK;

   for (genvar lane = 0; lane < gerd_pkg::NUM_BUTTONS; lane++) begin : g_lane
      gerd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (accept),
         .held    (cur_buttons[lane]),
         .cfg     (cfg_ff),
         .fire    (lane_fire[lane])
      );
   end

   // merge the lane decisions into one mask; unimplemented buttons read zero
   assign repeat_in = 32'(lane_fire);

   // ---------------------------------------------------------------
   // stick paths
   // ---------------------------------------------------------------
   logic signed [7:0] stick_x_in;
   logic signed [7:0] stick_y_in;

   gerd_stick u_stick_x (
      .raw       (req_stick_x_raw),
      .dead_zone (cfg_ff.dead_zone),
      .offset    (stick_x_in)
   );

   gerd_stick u_stick_y (
      .raw       (req_stick_y_raw),
      .dead_zone (cfg_ff.dead_zone),
      .offset    (stick_y_in)
   );

   // ---------------------------------------------------------------
   // edge detection against the previous frame, and the output register
   // ---------------------------------------------------------------
   logic [31:0]       prev_ff;
   logic [31:0]       pressed_ff;
   logic [31:0]       released_ff;
   logic [31:0]       held_ff;
   logic [31:0]       repeat_ff;
   logic signed [7:0] stick_x_ff;
   logic signed [7:0] stick_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            prev_ff      <= cur_buttons;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         pressed_ff  <= cur_buttons & ~prev_ff;
         released_ff <= ~cur_buttons & prev_ff;
         held_ff     <= cur_buttons;
         repeat_ff   <= repeat_in;
         stick_x_ff  <= stick_x_in;
         stick_y_ff  <= stick_y_in;
      end
   end

   assign rsp_pressed_mask   = pressed_ff;
   assign rsp_released_mask  = released_ff;
   assign rsp_held_mask      = held_ff;
   assign rsp_repeat_mask    = repeat_ff;
   assign rsp_stick_x_offset = stick_x_ff;
   assign rsp_stick_y_offset = stick_y_ff;

endmodule

// ===== bench/gamepad_edge_repeat_deadzone_unit_tb.sv =====
// Self-checking bench for gamepad_edge_repeat_deadzone_unit: directed frame table, then random phases.
// Response words are checked against typed answers or an in-bench decoder of edges, repeat, dead zone.
// Depends on gerd_pkg and the unit under test.
`timescale 1ns / 1ps

module gamepad_edge_repeat_deadzone_unit_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;
   // index past the end of the register list; the write must be dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // one decoded frame, as the response channel carries it
   typedef struct packed {
      logic [31:0] pressed;
      logic [31:0] released;
      logic [31:0] held;
      logic [31:0] rep;
      logic [7:0]  x_off;
      logic [7:0]  y_off;
   } decoded_frame_type;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [31:0]       buttons;
      logic [7:0]        x_raw;
      logic [7:0]        y_raw;
      logic [1:0]        csr_index;
      logic [7:0]        csr_data;
      logic              typed;
      decoded_frame_type want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic        [31:0] req_buttons = '0;
   logic        [7:0]  req_stick_x_raw = 8'd128;
   logic        [7:0]  req_stick_y_raw = 8'd128;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic        [31:0] rsp_pressed_mask;
   logic        [31:0] rsp_released_mask;
   logic        [31:0] rsp_held_mask;
   logic        [31:0] rsp_repeat_mask;
   logic signed [7:0]  rsp_stick_x_offset;
   logic signed [7:0]  rsp_stick_y_offset;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic        [1:0]  csr_index = '0;
   logic        [7:0]  csr_data = '0;

   // decoder state, kept in step with the unit
   gerd_pkg::cfg_type cfg = '{gerd_pkg::RESET_HOLD_DELAY, gerd_pkg::RESET_REPEAT_PERIOD,
                              gerd_pkg::RESET_DEAD_ZONE};
   logic [31:0]       last_buttons = '0;
   logic [8:0]        hold_count [32];
   decoded_frame_type pending_frames [$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int fault_count     = 0;
   int cycle_count     = 0;

   gamepad_edge_repeat_deadzone_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_buttons        (req_buttons),
      .req_stick_x_raw    (req_stick_x_raw),
      .req_stick_y_raw    (req_stick_y_raw),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pressed_mask   (rsp_pressed_mask),
      .rsp_released_mask  (rsp_released_mask),
      .rsp_held_mask      (rsp_held_mask),
      .rsp_repeat_mask    (rsp_repeat_mask),
      .rsp_stick_x_offset (rsp_stick_x_offset),
      .rsp_stick_y_offset (rsp_stick_y_offset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   function automatic directed_row_type frame_row(input logic [31:0] b, input logic [7:0] x,
                                                  input logic [7:0] y);
      return '{ROW_FRAME, b, x, y, 2'd0, 8'd0, 1'b0, '0};
   endfunction

   function automatic directed_row_type typed_row(input logic [31:0] b, input logic [7:0] x,
                                                  input logic [7:0] y,
                                                  input decoded_frame_type w);
      return '{ROW_FRAME, b, x, y, 2'd0, 8'd0, 1'b1, w};
   endfunction

   function automatic directed_row_type csr_row(input logic [1:0] index,
                                                input logic [7:0] data);
      return '{ROW_CSR, 32'h0, 8'd0, 8'd0, index, data, 1'b0, '0};
   endfunction

   // Directed table. Rows whose answer is plain from reset values carry it typed in;
   // the rest go through the decoder.
   directed_row_type directed_rows [26] = '{
      // reset config, idle pad, centred sticks
      typed_row(32'h0, 8'd128, 8'd128, '{32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00}),
      // every button pressed at once, sticks at both extremes
      typed_row(32'hFFFF_FFFF, 8'd0, 8'd255,
                '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80, 8'h7F}),
      // all released, sticks exactly on the dead zone edge
      typed_row(32'h0, 8'd108, 8'd148, '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'hEC, 8'h14}),
      // one step inside the dead zone
      typed_row(32'h0, 8'd109, 8'd147, '{32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00}),
      typed_row(32'h1, 8'd128, 8'd128, '{32'h1, 32'h0, 32'h1, 32'h1, 8'h00, 8'h00}),
      // short delay and period, then hold long enough to see pulses and a wrap
      csr_row(gerd_pkg::REG_HOLD_DELAY, 8'd2),
      csr_row(gerd_pkg::REG_REPEAT_PERIOD, 8'd3),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      frame_row(32'h8000_0001, 8'd200, 8'd50),
      // zero period in the middle of a hold
      csr_row(gerd_pkg::REG_REPEAT_PERIOD, 8'd0),
      frame_row(32'h8000_0001, 8'd255, 8'd0),
      frame_row(32'h8000_0001, 8'd255, 8'd0),
      // zero delay with counters already past it
      csr_row(gerd_pkg::REG_HOLD_DELAY, 8'd0),
      frame_row(32'h0001_0001, 8'd1, 8'd254),
      frame_row(32'h0001_0001, 8'd1, 8'd254),
      // dead zone above full scale blanks both sticks
      csr_row(gerd_pkg::REG_DEAD_ZONE, 8'd255),
      frame_row(32'h0, 8'd0, 8'd255),
      // write past the register list, then dead zone at its extremes
      csr_row(REG_UNUSED, 8'hFF),
      csr_row(gerd_pkg::REG_DEAD_ZONE, 8'd0),
      frame_row(32'h0, 8'd128, 8'd128),
      csr_row(gerd_pkg::REG_DEAD_ZONE, 8'd128),
      frame_row(32'h5A5A_A5A5, 8'd0, 8'd255)
   };

   initial begin
      forever #4 clock = ~clock;
   end

   // Centre one stick sample and blank it inside the dead zone.
   function automatic logic [7:0] centre_stick(input logic [7:0] raw);
      int c;
      int mag;
      c   = int'(raw) - 128;
      mag = (c < 0) ? -c : c;
      if (mag < int'(cfg.dead_zone))
         return 8'h00;
      return c[7:0];
   endfunction

   // Decode one accepted pad frame and advance the hold counters.
   function automatic void decode_frame(input logic [31:0] raw_buttons, input logic [7:0] x_raw,
                                        input logic [7:0] y_raw, output decoded_frame_type d);
      logic [31:0] cur;
      logic [31:0] rep;
      int          n;
      logic        fire;
      cur = raw_buttons & gerd_pkg::BUTTON_MASK;
      rep = '0;
      for (int i = 0; i < 32; i++) begin
         if (!cur[i]) begin
            hold_count[i] = '0;
         end else begin
            n    = int'(hold_count[i]) + 1;
            fire = (n == 1);
            // past the delay and a full period on: pulse and wrap back to the delay
            if (n > int'(cfg.hold_delay) &&
                n - int'(cfg.hold_delay) >= int'(cfg.repeat_period)) begin
               fire          = 1'b1;
               hold_count[i] = 9'(cfg.hold_delay);
            end else begin
               hold_count[i] = 9'(n);
            end
            rep[i] = fire;
         end
      end
      d.pressed    = cur & ~last_buttons;
      d.released   = ~cur & last_buttons;
      d.held       = cur;
      d.rep        = rep;
      d.x_off      = centre_stick(x_raw);
      d.y_off      = centre_stick(y_raw);
      last_buttons = cur;
   endfunction

   // Pick a stick sample: anywhere, a hard extreme, or right at the dead zone edge.
   function automatic logic [7:0] random_stick();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 255);
         1: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 255;
               2: v = 127;
               3: v = 128;
               default: v = 129;
            endcase
         end
         default: begin
            v = int'(cfg.dead_zone) + $urandom_range(0, 2) - 1;
            v = $urandom_range(0, 1) ? 128 + v : 128 - v;
         end
      endcase
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return v[7:0];
   endfunction

   // Offer one frame word, hold it through stalls, and queue its decode on acceptance.
   task automatic send_frame(input logic [31:0] b, input logic [7:0] x, input logic [7:0] y,
                             input logic typed, input decoded_frame_type want);
      decoded_frame_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_buttons     <= b;
      req_stick_x_raw <= x;
      req_stick_y_raw <= y;
      do @(posedge clock); while (req_stall);
      decode_frame(b, x, y, predicted);
      pending_frames.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Write one register, but only once every queued frame has come back.
   task automatic write_register(input logic [1:0] index, input logic [7:0] data);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         gerd_pkg::REG_HOLD_DELAY:    cfg.hold_delay    = data;
         gerd_pkg::REG_REPEAT_PERIOD: cfg.repeat_period = data;
         gerd_pkg::REG_DEAD_ZONE:     cfg.dead_zone     = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random phase: set all registers, then stream frames whose buttons mostly
   // stay put so that holds run deep into the repeat schedule.
   task automatic run_phase(input logic [7:0] delay, input logic [7:0] period,
                            input logic [7:0] dz, input int items, input int idle,
                            input int stall, input logic [31:0] pinned);
      logic [31:0] b;
      b = last_buttons;
      write_register(gerd_pkg::REG_HOLD_DELAY, delay);
      write_register(gerd_pkg::REG_REPEAT_PERIOD, period);
      write_register(gerd_pkg::REG_DEAD_ZONE, dz);
      sender_idle_pct = idle;
      stall_pct       = stall;
      for (int k = 0; k < items; k++) begin
         case ($urandom_range(0, 19))
            0:       b = $urandom;
            1:       b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: b = b ^ ($urandom & $urandom & $urandom & $urandom);
         endcase
         b = b | pinned;
         send_frame(b, random_stick(), random_stick(), 1'b0, '0);
      end
   endtask

   task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // Drive the receiver's stall at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Check every accepted response word against the oldest queued decode.
   always @(posedge clock) begin
      decoded_frame_type got;
      decoded_frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pressed_mask, rsp_released_mask, rsp_held_mask, rsp_repeat_mask,
                 rsp_stick_x_offset, rsp_stick_y_offset};
         if (pending_frames.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected response word: %h", got);
         end else begin
            want = pending_frames.pop_front();
            note_field("pressed_mask", want.pressed, got.pressed);
            note_field("released_mask", want.released, got.released);
            note_field("held_mask", want.held, got.held);
            note_field("repeat_mask", want.rep, got.rep);
            note_field("stick_x_offset", 32'(want.x_off), 32'(got.x_off));
            note_field("stick_y_offset", 32'(want.y_off), 32'(got.y_off));
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 32; i++)
         hold_count[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: no idling; each register write drops req_valid first
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_register(directed_rows[r].csr_index, directed_rows[r].csr_data);
         else
            send_frame(directed_rows[r].buttons, directed_rows[r].x_raw, directed_rows[r].y_raw,
                       directed_rows[r].typed, directed_rows[r].want);
      end

      // random phases; the last one pins the upper buttons so they reach the
      // counter ceiling with delay and period both at their maximum
      run_phase(8'd3,   8'd2,   8'd10,  250, 0,  0,  32'h0);
      run_phase(8'd1,   8'd1,   8'd128, 250, 78, 0,  32'h0);
      run_phase(8'd0,   8'd5,   8'd64,  250, 0,  78, 32'h0);
      run_phase(8'd7,   8'd0,   8'd0,   150, 22, 22, 32'h0);
      run_phase(8'd255, 8'd255, 8'd255, 600, 22, 22, 32'hFFFF_0000);
      req_valid <= 1'b0;

      // drain: wait for every queued frame, then a few quiet cycles
      while (pending_frames.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
